/* rtl/button_debounce_and_blink_pattern_core_assert.svh */
// Assertion macros for the button debounce and blink pattern core.
// Included inside the module body of the top level; no other dependencies.
`ifndef BUTTON_DEBOUNCE_AND_BLINK_PATTERN_CORE_ASSERT_SVH
`define BUTTON_DEBOUNCE_AND_BLINK_PATTERN_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BDB_ASSERT_SAME(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("bdb assertion failed in the same cycle");

// A property that must hold at every clock edge outside reset.
`define BDB_ASSERT_ALWAYS(label, clock, resetn, cond) \
    label: assert property (@(posedge clock) disable iff (!resetn) (cond)) \
        else $error("bdb invariant violated");

`endif

/* rtl/bdb_pkg.sv */
// Package for the button debounce and blink pattern core: widths, defaults,
// blink pattern codes and the pattern table functions. No dependencies.
package bdb_pkg;

    localparam int LEVEL_W  = 5;
    localparam int PAT_W    = 4;
    localparam int TICK_W   = 9;

    localparam int DEBOUNCE_COUNT_DEF = 6;
    localparam int BUTTON_COUNT_DEF   = 5;

    // Blink pattern codes; anything from PAT_STEADY upwards keeps the LED on.
    localparam logic [PAT_W-1:0] PAT_LONG   = 4'd0;
    localparam logic [PAT_W-1:0] PAT_MEDIUM = 4'd1;
    localparam logic [PAT_W-1:0] PAT_FAST   = 4'd2;
    localparam logic [PAT_W-1:0] PAT_SHORT  = 4'd3;
    localparam logic [PAT_W-1:0] PAT_DOUBLE = 4'd4;
    localparam logic [PAT_W-1:0] PAT_TRIPLE = 4'd5;
    localparam logic [PAT_W-1:0] PAT_STEADY = 4'd6;

    function automatic logic [TICK_W-1:0] blink_period(input logic [PAT_W-1:0] pat);
        case (pat)
            PAT_LONG:   return 9'd250;
            PAT_MEDIUM: return 9'd150;
            PAT_FAST:   return 9'd50;
            PAT_SHORT:  return 9'd250;
            PAT_DOUBLE: return 9'd350;
            default:    return 9'd450;
        endcase
    endfunction

    function automatic logic blink_led(input logic [PAT_W-1:0] pat,
                                       input logic [TICK_W-1:0] t);
        case (pat)
            PAT_LONG:   return t < 9'd200;
            PAT_MEDIUM: return t < 9'd75;
            PAT_FAST:   return t < 9'd25;
            PAT_SHORT:  return t < 9'd50;
            PAT_DOUBLE: return (t < 9'd50) || (t >= 9'd100 && t < 9'd150);
            default:    return (t < 9'd50) || (t >= 9'd100 && t < 9'd150)
                               || (t >= 9'd200 && t < 9'd250);
        endcase
    endfunction

endpackage

/* rtl/button_debounce_and_blink_pattern_core.sv */
// Button debounce and LED blink pattern core, top level.
// Depends on bdb_pkg and the assertion macro header.
//
// Usage:
// - Input channel (in_valid, in_stall, button_levels): one word per 10 ms tick
//   carrying the raw levels of buttons 2..6, bit 0 being button 2.
// - Output channel (out_valid, out_stall, press_events, display_mode_event,
//   led_level, wake_pulse): exactly one result word for every input word.
// - Configuration: cfg_wr_en with cfg_wr_data writes the blink pattern and
//   restarts the blink tick counter. Write only while no word is in flight.
// A result is offered once its input word has passed the input register and
// the debounce and blink update has run in a single pass into the result
// register. Throughput is one word per cycle while out_stall is low, set by
// that single-pass update of the button and tick state.
// A result waiting under out_stall does not block the input register, which
// still takes one more word; in_stall rises only when both stages are full.
// Reset clears all debounce counters and flags, the tick counter, the blink
// pattern (pattern zero) and both valid stages.
module button_debounce_and_blink_pattern_core #(
    parameter int DEBOUNCE_COUNT = bdb_pkg::DEBOUNCE_COUNT_DEF,
    parameter int BUTTON_COUNT   = bdb_pkg::BUTTON_COUNT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [bdb_pkg::PAT_W-1:0]   cfg_wr_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [bdb_pkg::LEVEL_W-1:0] button_levels,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [bdb_pkg::LEVEL_W-1:0] press_events,
    output logic                        display_mode_event,
    output logic                        led_level,
    output logic                        wake_pulse
);
    import bdb_pkg::*;

    localparam int CNT_W = (DEBOUNCE_COUNT > 2) ? $clog2(DEBOUNCE_COUNT) : 1;
    localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(DEBOUNCE_COUNT - 1);

    // Handshake and pipeline control.
    logic               s1_valid_reg, s1_valid_next;
    logic               out_valid_reg, out_valid_next;
    logic [LEVEL_W-1:0] s1_levels_reg;
    logic               s2_load, s1_fire, in_take;

    // Debounce and blink state.
    logic [CNT_W-1:0]   cnt_reg [BUTTON_COUNT];
    logic [CNT_W-1:0]   cnt_next [BUTTON_COUNT];
    logic [BUTTON_COUNT-1:0] flag_reg, flag_next;
    logic [BUTTON_COUNT-1:0] press_vec;
    logic [PAT_W-1:0]   pattern_reg;
    logic [TICK_W-1:0]  ticks_reg, ticks_next;

    // Result register.
    logic [LEVEL_W-1:0] press_events_reg, press_events_next;
    logic               led_level_reg, led_level_next;
    logic               wake_pulse_reg, wake_pulse_next;

    logic               steady;
    logic [TICK_W:0]    tick_inc;
    logic               wrap;

    assign s2_load  = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && s2_load;
    assign in_stall = s1_valid_reg && !s2_load;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (s2_load)
        begin
            out_valid_next = 1'b0;
        end
    end

    // One debouncer per button; buttons beyond the input word never see a press.
    for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_btn
        logic level;
        if (i < LEVEL_W) begin : g_live
            assign level = s1_levels_reg[i];
        end
        else begin : g_dead
            assign level = 1'b0;
        end

        always_comb
        begin
            press_vec[i] = 1'b0;
            flag_next[i] = flag_reg[i];
            cnt_next[i]  = cnt_reg[i];
            if (level)
            begin
                if (cnt_reg[i] == CNT_TOP && !flag_reg[i])
                begin
                    flag_next[i] = 1'b1;
                    press_vec[i] = 1'b1;
                end
                else if (cnt_reg[i] == '0 && flag_reg[i])
                begin
                    flag_next[i] = 1'b0;
                end
                if (cnt_reg[i] < CNT_TOP)
                begin
                    cnt_next[i] = cnt_reg[i] + 1'b1;
                end
            end
            else if (cnt_reg[i] != '0)
            begin
                cnt_next[i] = cnt_reg[i] - 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cnt_reg[i]  <= '0;
                flag_reg[i] <= 1'b0;
            end
            else if (s1_fire)
            begin
                cnt_reg[i]  <= cnt_next[i];
                flag_reg[i] <= flag_next[i];
            end
        end
    end

    for (genvar k = 0; k < LEVEL_W; k++) begin : g_press
        if (k < BUTTON_COUNT) begin : g_used
            assign press_events_next[k] = press_vec[k];
        end
        else begin : g_unused
            assign press_events_next[k] = 1'b0;
        end
    end

    // Blink generator: the tick counter is held while the LED is steadily on.
    always_comb
    begin
        steady         = pattern_reg >= PAT_STEADY;
        tick_inc       = {1'b0, ticks_reg} + 1'b1;
        wrap           = !steady && (tick_inc >= {1'b0, blink_period(pattern_reg)});
        led_level_next = steady || blink_led(pattern_reg, ticks_reg);
        if (steady)
        begin
            ticks_next = ticks_reg;
        end
        else if (wrap)
        begin
            ticks_next = '0;
        end
        else
        begin
            ticks_next = tick_inc[TICK_W-1:0];
        end
        wake_pulse_next = wrap || (|press_events_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pattern_reg   <= PAT_LONG;
            ticks_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                pattern_reg <= cfg_wr_data;
                ticks_reg   <= '0;
            end
            else if (s1_fire)
            begin
                ticks_reg <= ticks_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_levels_reg <= button_levels;
        end
        if (s1_fire)
        begin
            press_events_reg <= press_events_next;
            led_level_reg    <= led_level_next;
            wake_pulse_reg   <= wake_pulse_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign press_events       = press_events_reg;
    assign display_mode_event = press_events_reg[0];
    assign led_level          = led_level_reg;
    assign wake_pulse         = wake_pulse_reg;

    `include "button_debounce_and_blink_pattern_core_assert.svh"

    // A recognised press must always raise wake in the same word.
    `BDB_ASSERT_SAME(a_press_wakes, clk, rst_n, out_valid && (|press_events), wake_pulse)
    // The tick counter never reaches the period of the selected pattern.
    `BDB_ASSERT_ALWAYS(a_ticks_in_period, clk, rst_n, ticks_reg < blink_period(pattern_reg))
    // The first debounce counter saturates at its top value.
    `BDB_ASSERT_ALWAYS(a_cnt_saturates, clk, rst_n, cnt_reg[0] <= CNT_TOP)

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for button_debounce_and_blink_pattern_core: a
// per-tick predictor of the debounce and blink state checks every result word.
// Depends on bdb_pkg and the core RTL only.
module testbench;
    import bdb_pkg::*;

    localparam int NB          = BUTTON_COUNT_DEF;
    localparam int TOP_COUNT   = DEBOUNCE_COUNT_DEF - 1;
    localparam int WATCH_LIMIT = 1000;
    localparam int HOLD_CYCLES = 60;
    localparam logic [PAT_W-1:0] PAT_MAX = '1;

    typedef struct packed {
        logic [LEVEL_W-1:0] press;
        logic               disp;
        logic               led;
        logic               wake;
    } tick_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [PAT_W-1:0]   cfg_wr_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [LEVEL_W-1:0] button_levels = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [LEVEL_W-1:0] press_events;
    logic               display_mode_event;
    logic               led_level;
    logic               wake_pulse;

    button_debounce_and_blink_pattern_core u_top (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .button_levels      (button_levels),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .press_events       (press_events),
        .display_mode_event (display_mode_event),
        .led_level          (led_level),
        .wake_pulse         (wake_pulse)
    );

    // Predicted state of the block
    logic [2:0]         bounce_cnt [NB] = '{default: '0};
    logic               held_flag [NB] = '{default: 1'b0};
    logic [TICK_W-1:0]  blink_count = '0;
    logic [PAT_W-1:0]   cur_pattern = '0;

    logic [LEVEL_W-1:0] pending_levels [$];
    tick_result_t       expected_ticks [$];
    int                 fail_count = 0;
    int                 idle_cycles = 0;
    logic               in_taken = 1'b0;

    // Driver and receiver state
    int                 burst_left = 1;
    int                 gap_left = 0;
    int                 stall_cycle = 0;
    int                 hold_left = 0;
    int                 stall_mode = 0;

    // Per-button level runs used to build realistic press and release sequences
    logic               run_level [NB] = '{default: 1'b0};
    int                 run_left [NB] = '{default: 0};

    initial begin
        forever #6 clk = ~clk;
    end

    function automatic tick_result_t predict_tick(input logic [LEVEL_W-1:0] levels);
        tick_result_t r;
        logic [TICK_W:0] period;
        logic [TICK_W:0] t;
        r = '0;
        for (int b = 0; b < NB; b++) begin
            if (levels[b]) begin
                if (bounce_cnt[b] == TOP_COUNT && !held_flag[b]) begin
                    held_flag[b] = 1'b1;
                    r.press[b] = 1'b1;
                end else if (bounce_cnt[b] == 0 && held_flag[b]) begin
                    held_flag[b] = 1'b0;
                end
                if (bounce_cnt[b] < TOP_COUNT)
                    bounce_cnt[b] = bounce_cnt[b] + 3'd1;
            end else if (bounce_cnt[b] > 0) begin
                bounce_cnt[b] = bounce_cnt[b] - 3'd1;
            end
        end
        if (cur_pattern >= PAT_STEADY) begin
            r.led = 1'b1;
        end else begin
            t = {1'b0, blink_count};
            case (cur_pattern)
                PAT_LONG:
                begin
                    period = (TICK_W+1)'(250);
                    r.led = t < 200;
                end
                PAT_MEDIUM:
                begin
                    period = (TICK_W+1)'(150);
                    r.led = t < 75;
                end
                PAT_FAST:
                begin
                    period = (TICK_W+1)'(50);
                    r.led = t < 25;
                end
                PAT_SHORT:
                begin
                    period = (TICK_W+1)'(250);
                    r.led = t < 50;
                end
                PAT_DOUBLE:
                begin
                    period = (TICK_W+1)'(350);
                    r.led = t < 50 || (t >= 100 && t < 150);
                end
                default:
                begin
                    period = (TICK_W+1)'(450);
                    r.led = t < 50 || (t >= 100 && t < 150) || (t >= 200 && t < 250);
                end
            endcase
            if (t + 1 >= period) begin
                blink_count = '0;
                r.wake = 1'b1;
            end else begin
                blink_count = blink_count + 1'b1;
            end
        end
        r.disp = r.press[0];
        if (r.press != '0)
            r.wake = 1'b1;
        return r;
    endfunction

    // Mostly held levels with occasional one or two tick glitches, and some noise.
    function automatic logic [LEVEL_W-1:0] next_levels();
        logic [LEVEL_W-1:0] lv;
        if ($urandom_range(0, 9) == 0)
            return LEVEL_W'($urandom_range(0, 31));
        for (int b = 0; b < NB; b++) begin
            if (run_left[b] == 0) begin
                run_level[b] = ~run_level[b];
                run_left[b] = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2)
                                                          : $urandom_range(4, 14);
            end
            run_left[b]--;
            lv[b] = run_level[b];
        end
        return lv;
    endfunction

    // Checked at the rising edge, where the sender's queue and valid are settled.
    task automatic wait_idle();
        while (pending_levels.size() != 0 || in_valid || expected_ticks.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_pattern(input logic [PAT_W-1:0] pat);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= pat;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Sender: bursts of words separated by random gaps
    always @(negedge clk) begin
        logic next_valid;
        if (rst_n && !(in_valid && !in_taken)) begin
            next_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_levels.size() != 0) begin
                button_levels <= pending_levels.pop_front();
                next_valid = 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 30);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            in_valid <= next_valid;
        end
    end

    // Receiver: stall pattern of its own, with a long hold-off now and then so
    // that both stages fill and the input side stalls.
    always @(negedge clk) begin
        if (rst_n) begin
            stall_cycle++;
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (stall_cycle % 1500 == 600) begin
                hold_left = HOLD_CYCLES;
                out_stall <= 1'b1;
            end else begin
                if (stall_cycle % 64 == 0)
                    stall_mode = $urandom_range(0, 3);
                case (stall_mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= stall_cycle[2];
                    default: out_stall <= ($urandom_range(0, 1) == 0);
                endcase
            end
        end
    end

    // Monitor: predicts on every accepted input word, checks every result word
    always @(posedge clk) begin
        tick_result_t want;
        if (rst_n) begin
            in_taken <= in_valid && !in_stall;
            if (cfg_wr_en) begin
                cur_pattern = cfg_wr_data;
                blink_count = '0;
            end
            if (out_valid && !out_stall) begin
                if (expected_ticks.size() == 0) begin
                    $error("result word with nothing expected");
                    fail_count++;
                end else begin
                    want = expected_ticks.pop_front();
                    if (press_events !== want.press) begin
                        $error("press_events: expected %0h, actual %0h", want.press, press_events);
                        fail_count++;
                    end
                    if (display_mode_event !== want.disp) begin
                        $error("display_mode_event: expected %0b, actual %0b",
                               want.disp, display_mode_event);
                        fail_count++;
                    end
                    if (led_level !== want.led) begin
                        $error("led_level: expected %0b, actual %0b", want.led, led_level);
                        fail_count++;
                    end
                    if (wake_pulse !== want.wake) begin
                        $error("wake_pulse: expected %0b, actual %0b", want.wake, wake_pulse);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_ticks.push_back(predict_tick(button_levels));
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCH_LIMIT) begin
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    initial begin
        logic [PAT_W-1:0] phase_pat [8];
        int               phase_len [8];
        phase_pat = '{PAT_FAST, PAT_MEDIUM, PAT_MAX, PAT_LONG, PAT_SHORT, PAT_DOUBLE,
                      PAT_STEADY, PAT_TRIPLE};
        phase_len = '{120, 160, 80, 260, 80, 360, 60, 460};
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: all released, all pressed until every button fires, hold,
        // release to zero, press again to clear the flags, then fire again.
        write_pattern(PAT_LONG);
        pending_levels.push_back('0);
        repeat (7) pending_levels.push_back('1);
        repeat (5) pending_levels.push_back('0);
        repeat (6) pending_levels.push_back('1);
        pending_levels.push_back(LEVEL_W'(5'b10101));
        pending_levels.push_back(LEVEL_W'(5'b01010));
        wait_idle();

        for (int p = 0; p < 8; p++) begin
            write_pattern(phase_pat[p]);
            repeat (phase_len[p]) pending_levels.push_back(next_levels());
            wait_idle();
        end

        repeat (8) @(negedge clk);
        if (fail_count == 0 && expected_ticks.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/bdb_pkg.sv
rtl/button_debounce_and_blink_pattern_core.sv
tb/sv/testbench.sv
